FILE: hdl/fud_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fud_pkg
// types, codes and helpers shared by the urlencoded form decoder
// ----------------------------------------------------------------------------
package fud_pkg;

  localparam logic [7:0] CHAR_PCT = 8'h25;
  localparam logic [7:0] CHAR_AMP = 8'h26;
  localparam logic [7:0] CHAR_EQ  = 8'h3d;

  localparam int unsigned MaxResults = 3;

  typedef enum logic [2:0] {
    KIND_KEY     = 3'd0,
    KIND_VALUE   = 3'd1,
    KIND_KEY_END = 3'd2,
    KIND_PAIR    = 3'd3,
    KIND_DISCARD = 3'd4
  } kind_e;

  typedef struct packed {
    logic       in_value;
    logic [1:0] pend_cnt;
    logic [7:0] pend_char;
    logic       seg_started;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t [MaxResults-1:0] r;
  } res_list_t;

  // appends one result, ignored once the list is full
  function automatic res_list_t push(res_list_t l, logic [7:0] b, kind_e k);
    res_list_t o;
    o = l;
    case (l.n)
      2'd0: begin
        o.r[0] = '{data: b, kind: k};
        o.n    = 2'd1;
      end
      2'd1: begin
        o.r[1] = '{data: b, kind: k};
        o.n    = 2'd2;
      end
      2'd2: begin
        o.r[2] = '{data: b, kind: k};
        o.n    = 2'd3;
      end
      default: o = l;
    endcase
    return o;
  endfunction

  // bit 4 set when the char is not a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/fud_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fud_core
// combinational decode of one body byte against the parser state
// ----------------------------------------------------------------------------
module fud_core (
  input  fud_pkg::dec_state_t st_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output fud_pkg::dec_state_t st_o,
  output fud_pkg::res_list_t  res_o
);
  import fud_pkg::*;

  function automatic res_list_t flush_pend(dec_state_t fs, kind_e fk, res_list_t fl);
    res_list_t o;
    o = fl;
    if (fs.pend_cnt != 2'd0) o = push(o, CHAR_PCT, fk);
    if (fs.pend_cnt[1])      o = push(o, fs.pend_char, fk);
    return o;
  endfunction

  function automatic res_list_t close_seg(dec_state_t cs, res_list_t cl);
    res_list_t o;
    o = cl;
    if (cs.in_value) begin
      o = flush_pend(cs, KIND_VALUE, o);
      o = push(o, 8'h00, KIND_PAIR);
    end else if (cs.seg_started) begin
      o = push(o, 8'h00, KIND_DISCARD);
    end
    return o;
  endfunction

  dec_state_t s;
  res_list_t  l;
  kind_e      k;
  logic [7:0] first;
  logic [4:0] h1;
  logic [4:0] h2;

  always_comb begin
    s     = st_i;
    l     = '0;
    k     = st_i.in_value ? KIND_VALUE : KIND_KEY;
    first = st_i.pend_char;
    h1    = hex_val(st_i.pend_char);
    h2    = hex_val(byte_i);
    if (byte_i == CHAR_AMP) begin
      l = close_seg(s, l);
      s = '0;
    end else if (byte_i == CHAR_EQ && !st_i.in_value) begin
      l = flush_pend(s, KIND_KEY, l);
      if (last_i) begin
        l = push(l, 8'h00, KIND_PAIR);
        s = '0;
      end else begin
        l = push(l, 8'h00, KIND_KEY_END);
        s = '{in_value: 1'b1, pend_cnt: 2'd0, pend_char: 8'h00, seg_started: 1'b1};
      end
    end else begin
      s.seg_started = 1'b1;
      case (st_i.pend_cnt)
        2'd0: begin
          if (byte_i == CHAR_PCT) s.pend_cnt = 2'd1;
          else l = push(l, byte_i, k);
        end
        2'd1: begin
          s.pend_cnt  = 2'd2;
          s.pend_char = byte_i;
        end
        default: begin
          s.pend_cnt  = 2'd0;
          s.pend_char = 8'h00;
          if (!h1[4] && !h2[4]) begin
            l = push(l, {h1[3:0], h2[3:0]}, k);
          end else if (first == CHAR_PCT) begin
            s.pend_cnt  = 2'd2;
            s.pend_char = byte_i;
          end else begin
            l = push(l, first, k);
            if (byte_i == CHAR_PCT) s.pend_cnt = 2'd1;
            else l = push(l, byte_i, k);
          end
        end
      endcase
      if (last_i) begin
        l = close_seg(s, l);
        s = '0;
      end
    end
    st_o  = s;
    res_o = l;
  end

endmodule
`default_nettype wire

FILE: hdl/form_urlencoded_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// form_urlencoded_decoder
// streaming decoder for an application/x-www-form-urlencoded body
// ----------------------------------------------------------------------------
// body bytes enter on the s_axis channel, tlast flags the final byte of the
// body. decoded words leave on the m_axis channel: tdata is the byte (zero
// for markers), tuser the kind (key byte, value byte, key ended, pair
// complete, segment discarded) and tlast flags the final word caused by one
// input byte. a byte causes zero to three words.
// a byte waits in the input register (or the skid entry behind it), is
// decoded combinationally and its words are loaded into the result register
// that drives m_axis. throughput: one byte per cycle while each byte gives
// at most one word and m_axis is ready; a byte giving more words holds the
// input until the single output port drains the result register, one word
// a cycle while m_axis is ready. a two-entry input buffer keeps s_axis_tready
// registered, so a stall on m_axis reaches the input once the skid entry is
// full; nothing is lost or dropped. reset clears the parser state and both
// buffers, the block then waits in the key state of an empty segment.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // data_byte
  input  logic       s_axis_tlast_i,   // body_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // out_byte
  output logic [2:0] m_axis_tuser_o,   // kind
  output logic       m_axis_tlast_o    // last_of_run
);
  import fud_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_last_q, in_last_d;
  logic       sk_valid_q, sk_valid_d;
  logic [7:0] sk_byte_q, sk_byte_d;
  logic       sk_last_q, sk_last_d;

  dec_state_t st_q, st_d;
  res_list_t  res;

  logic                  ob_valid_q, ob_valid_d;
  logic [1:0]            ob_cnt_q, ob_cnt_d;
  logic [1:0]            ob_idx_q, ob_idx_d;
  res_t [MaxResults-1:0] ob_q, ob_d;

  logic s_acc, m_acc, ob_last, load_ok, move, main_free;

  fud_core u_core (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  assign s_axis_tready_o = !sk_valid_q;
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc     = m_axis_tvalid_o && m_axis_tready_i;
  assign ob_last   = (ob_idx_q == ob_cnt_q - 2'd1);
  assign load_ok   = !ob_valid_q || (ob_last && m_axis_tready_i);
  assign move      = in_valid_q && load_ok;
  assign main_free = !in_valid_q || move;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    in_last_d  = in_last_q;
    sk_valid_d = sk_valid_q;
    sk_byte_d  = sk_byte_q;
    sk_last_d  = sk_last_q;
    if (main_free) begin
      if (sk_valid_q) begin
        in_valid_d = 1'b1;
        in_byte_d  = sk_byte_q;
        in_last_d  = sk_last_q;
        sk_valid_d = 1'b0;
      end else begin
        in_valid_d = s_acc;
        in_byte_d  = s_axis_tdata_i;
        in_last_d  = s_axis_tlast_i;
      end
    end else if (s_acc) begin
      sk_valid_d = 1'b1;
      sk_byte_d  = s_axis_tdata_i;
      sk_last_d  = s_axis_tlast_i;
    end
  end

  always_comb begin
    ob_valid_d = ob_valid_q;
    ob_cnt_d   = ob_cnt_q;
    ob_idx_d   = ob_idx_q;
    ob_d       = ob_q;
    if (move) begin
      ob_valid_d = (res.n != 2'd0);
      ob_cnt_d   = res.n;
      ob_idx_d   = 2'd0;
      ob_d       = res.r;
    end else if (m_acc) begin
      if (ob_last) ob_valid_d = 1'b0;
      else ob_idx_d = ob_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      sk_valid_q <= 1'b0;
      ob_valid_q <= 1'b0;
      ob_cnt_q   <= 2'd0;
      ob_idx_q   <= 2'd0;
      st_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      sk_valid_q <= sk_valid_d;
      ob_valid_q <= ob_valid_d;
      ob_cnt_q   <= ob_cnt_d;
      ob_idx_q   <= ob_idx_d;
      if (move) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_last_q <= in_last_d;
    sk_byte_q <= sk_byte_d;
    sk_last_q <= sk_last_d;
    ob_q      <= ob_d;
  end

  assign m_axis_tvalid_o = ob_valid_q;
  assign m_axis_tdata_o  = ob_q[ob_idx_q].data;
  assign m_axis_tuser_o  = ob_q[ob_idx_q].kind;
  assign m_axis_tlast_o  = ob_last;

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_valid_q |-> ob_cnt_q != 2'd0)
    else $error("result register valid with no words");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_valid_q |-> ob_idx_q < ob_cnt_q)
    else $error("result index past word count");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> in_valid_q)
    else $error("skid entry held with empty input register");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pend_cnt != 2'd3)
    else $error("pending escape count out of range");

endmodule
`default_nettype wire

FILE: verif/form_urlencoded_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_tb
// drives urlencoded form bodies into the decoder and checks every output
// word against a decoder written here (or, in typed rows, against the table):
// a directed table of edge cases, then random bodies of well-formed pairs with
// escapes, broken escapes and noise, under changing back-pressure on both sides
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_tb;
  import fud_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    logic [1:0] n;
    word_t      w0;
    word_t      w1;
    word_t      w2;
  } row_t;

  localparam word_t NO_WORD = '0;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // data_byte
  logic       s_axis_tlast_i = 1'b0;    // body_end
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // out_byte
  logic [2:0] m_axis_tuser_o;           // kind
  logic       m_axis_tlast_o;           // last_of_run

  form_urlencoded_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  int unsigned send_idle_pct = 9;
  int unsigned recv_stall_pct = 78;
  int unsigned fail_cnt = 0;

  word_t      due_words[$];
  word_t      step_words[$];
  logic [7:0] body_q[$];
  row_t       dir_tab[$];

  // decoder state
  logic       dec_in_value = 1'b0;
  logic [1:0] dec_pend_cnt = 2'd0;
  logic [7:0] dec_pend_char = 8'h00;
  logic       dec_seg_started = 1'b0;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic kind_e part_kind();
    return dec_in_value ? KIND_VALUE : KIND_KEY;
  endfunction

  task automatic put_word(input logic [7:0] b, input kind_e k);
    if (step_words.size() < MaxResults) begin
      step_words.push_back('{data: b, kind: k, last: 1'b0});
    end
  endtask

  task automatic take_plain(input logic [7:0] c);
    if (c == CHAR_PCT) begin
      dec_pend_cnt = 2'd1;
    end else begin
      put_word(c, part_kind());
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    int h1;
    int h2;
    logic [7:0] held;
    if (dec_pend_cnt == 2'd0) begin
      take_plain(c);
    end else if (dec_pend_cnt == 2'd1) begin
      dec_pend_cnt = 2'd2;
      dec_pend_char = c;
    end else begin
      held = dec_pend_char;
      h1 = hex_digit(held);
      h2 = hex_digit(c);
      dec_pend_cnt = 2'd0;
      dec_pend_char = 8'h00;
      if (h1 >= 0 && h2 >= 0) begin
        put_word(8'(h1 * 16 + h2), part_kind());
      end else begin
        // bad escape: percent dropped, both chars taken again
        take_plain(held);
        if (dec_pend_cnt == 2'd0) begin
          take_plain(c);
        end else begin
          dec_pend_cnt = 2'd2;
          dec_pend_char = c;
        end
      end
    end
  endtask

  task automatic flush_held();
    if (dec_pend_cnt >= 2'd1) put_word(CHAR_PCT, part_kind());
    if (dec_pend_cnt >= 2'd2) put_word(dec_pend_char, part_kind());
    dec_pend_cnt = 2'd0;
    dec_pend_char = 8'h00;
  endtask

  task automatic clear_segment();
    dec_in_value = 1'b0;
    dec_pend_cnt = 2'd0;
    dec_pend_char = 8'h00;
    dec_seg_started = 1'b0;
  endtask

  task automatic close_segment();
    if (dec_in_value) begin
      flush_held();
      put_word(8'h00, KIND_PAIR);
    end else if (dec_seg_started) begin
      put_word(8'h00, KIND_DISCARD);
    end
    clear_segment();
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic fin);
    word_t w;
    step_words.delete();
    if (c == CHAR_AMP) begin
      close_segment();
    end else if (c == CHAR_EQ && !dec_in_value) begin
      dec_seg_started = 1'b1;
      flush_held();
      dec_in_value = 1'b1;
      if (fin) begin
        put_word(8'h00, KIND_PAIR);
        clear_segment();
      end else begin
        put_word(8'h00, KIND_KEY_END);
      end
    end else begin
      dec_seg_started = 1'b1;
      take_char(c);
      if (fin) close_segment();
    end
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
    end
  endtask

  function automatic word_t wd(logic [7:0] d, kind_e k, logic t);
    return '{data: d, kind: k, last: t};
  endfunction

  function automatic row_t row(logic [7:0] b, logic l);
    return '{b: b, l: l, typed: 1'b0, n: 2'd0, w0: NO_WORD, w1: NO_WORD, w2: NO_WORD};
  endfunction

  function automatic row_t trow(logic [7:0] b, logic l, logic [1:0] n,
                                word_t w0, word_t w1, word_t w2);
    return '{b: b, l: l, typed: 1'b1, n: n, w0: w0, w1: w1, w2: w2};
  endfunction

  // one byte through the handshake, expectations queued once it is taken
  task automatic drive_byte(input row_t r);
    int unsigned idle;
    idle = 0;
    while (idle < 40 && $urandom_range(0, 99) < send_idle_pct) idle++;
    if (idle > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= r.b;
    s_axis_tlast_i  <= r.l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decode_byte(r.b, r.l);
    if (r.typed) begin
      if (r.n >= 2'd1) due_words.push_back(r.w0);
      if (r.n >= 2'd2) due_words.push_back(r.w1);
      if (r.n >= 2'd3) due_words.push_back(r.w2);
    end else begin
      foreach (step_words[i]) due_words.push_back(step_words[i]);
    end
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7e));
    if (c == CHAR_AMP || c == CHAR_PCT || c == CHAR_EQ) c = "x";
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) return 8'("0" + idx);
    if (idx < 16) return 8'("a" + idx - 10);
    return 8'("A" + idx - 16);
  endfunction

  task automatic add_part(input logic in_val);
    int unsigned n;
    int unsigned k;
    int unsigned r;
    logic [7:0] c;
    n = $urandom_range(0, 5);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        body_q.push_back(text_char());
      end else if (r < 60) begin
        body_q.push_back(CHAR_PCT);
        body_q.push_back(hex_char());
        body_q.push_back(hex_char());
      end else if (r < 70) begin
        body_q.push_back(CHAR_PCT);
        body_q.push_back(text_char());
        body_q.push_back(text_char());
      end else if (r < 76) begin
        body_q.push_back("+");
      end else if (r < 86) begin
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_AMP || (!in_val && c == CHAR_EQ)) c = 8'h00;
        body_q.push_back(c);
      end else if (r < 92 && in_val) begin
        body_q.push_back(CHAR_EQ);
      end else begin
        // escape cut short by the end of the part
        body_q.push_back(CHAR_PCT);
        if ($urandom_range(0, 1) == 1) body_q.push_back(hex_char());
        break;
      end
    end
  endtask

  task automatic build_body(output logic noise);
    int unsigned npair;
    int unsigned i;
    body_q.delete();
    noise = ($urandom_range(0, 99) < 12);
    if (noise) begin
      repeat ($urandom_range(1, 10)) body_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      npair = $urandom_range(1, 4);
      for (i = 0; i < npair; i++) begin
        if (i > 0) body_q.push_back(CHAR_AMP);
        add_part(1'b0);
        if ($urandom_range(0, 99) < 85) begin
          body_q.push_back(CHAR_EQ);
          add_part(1'b1);
        end
      end
      if ($urandom_range(0, 99) < 10) body_q.push_back(CHAR_AMP);
      if (body_q.size() == 0) body_q.push_back(text_char());
    end
  endtask

  initial begin : stimulus
    int unsigned rnd_cnt;
    int unsigned i;
    logic noise;
    logic fin;
    dir_tab = '{
      trow(8'h00, 1'b0, 2'd1, wd(8'h00, KIND_KEY, 1'b1), NO_WORD, NO_WORD),
      trow(8'hff, 1'b1, 2'd2, wd(8'hff, KIND_KEY, 1'b0),
           wd(8'h00, KIND_DISCARD, 1'b1), NO_WORD),
      trow(CHAR_AMP, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD),
      row("k", 1'b0), row(CHAR_PCT, 1'b0), row("4", 1'b0), row("1", 1'b0),
      row(CHAR_EQ, 1'b0),
      row(CHAR_PCT, 1'b0), row("f", 1'b0), row("F", 1'b0),
      row(CHAR_EQ, 1'b0), row("+", 1'b0),
      row(CHAR_PCT, 1'b0), row(CHAR_PCT, 1'b0), row("4", 1'b0), row("z", 1'b0),
      row(CHAR_PCT, 1'b0), row("z", 1'b0), row(CHAR_AMP, 1'b0),
      trow(CHAR_EQ, 1'b1, 2'd1, wd(8'h00, KIND_PAIR, 1'b1), NO_WORD, NO_WORD),
      row(CHAR_PCT, 1'b1),
      row(CHAR_EQ, 1'b0), row(CHAR_PCT, 1'b0), row("A", 1'b1),
      trow(CHAR_AMP, 1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD)
    };
    rnd_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[j]) drive_byte(dir_tab[j]);
    while (rnd_cnt < 430) begin
      if (rnd_cnt >= 287) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (rnd_cnt >= 143) begin
        send_idle_pct = 78;
        recv_stall_pct = 9;
      end
      build_body(noise);
      for (i = 0; i < body_q.size(); i++) begin
        fin = noise ? ($urandom_range(0, 3) == 0) : (i == body_q.size() - 1);
        drive_byte(row(body_q[i], fin));
        rnd_cnt++;
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && due_words.size() == 0) begin
      $display("form_urlencoded_decoder_tb passed");
    end else begin
      $display("form_urlencoded_decoder_tb failed");
    end
    $finish;
  end

  initial begin : sink
    word_t got;
    word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{data: m_axis_tdata_o, kind: m_axis_tuser_o, last: m_axis_tlast_o};
        if (due_words.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected word, expected none, got data %02h kind %0d last %0b",
                   $time, got.data, got.kind, got.last);
        end else begin
          want = due_words.pop_front();
          if (got.data !== want.data || got.kind !== want.kind || got.last !== want.last) begin
            fail_cnt++;
            $display({"%0t: word mismatch, expected data %02h kind %0d last %0b, ",
                      "got data %02h kind %0d last %0b"},
                     $time, want.data, want.kind, want.last, got.data, got.kind, got.last);
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    #2000000;
    $display("form_urlencoded_decoder_tb failed");
    $finish;
  end

endmodule
